FILE: rtl/asef_pkg.sv
// shared constants and types for the ansi sgr escape filter
`timescale 1ns / 1ps

package asef_pkg;

  localparam int unsigned MAX_SEQ_CHARS = 15;
  localparam int unsigned MAX_PARAMS    = 5;
  localparam int unsigned PARAM_W       = 16;
  localparam int unsigned COUNT_W       = 3;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned OUT_DATA_W    = 96;

  localparam logic [BYTE_W-1:0] CH_ESC      = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_M        = 8'h6D;
  localparam logic [BYTE_W-1:0] CH_SEMI     = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_ZERO     = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE     = 8'h39;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_SGR  = 1'b1;

  typedef struct packed {
    logic                                kind;
    logic [MAX_PARAMS-1:0][PARAM_W-1:0]  values;
    logic [COUNT_W-1:0]                  count;
    logic [BYTE_W-1:0]                   chr;
  } sgr_result_t;

endpackage

FILE: rtl/asef_parser.sv
// escape sequence state and per-byte parse step
`timescale 1ns / 1ps

module asef_parser #(
  parameter int unsigned MAX_SEQ_CHARS = asef_pkg::MAX_SEQ_CHARS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [asef_pkg::BYTE_W-1:0]   byte_in,
  output logic                          emit,
  output asef_pkg::sgr_result_t         res
);

  localparam int unsigned SEQ_W = $clog2(MAX_SEQ_CHARS + 1);
  localparam int unsigned NP    = asef_pkg::MAX_PARAMS;
  localparam int unsigned PW    = asef_pkg::PARAM_W;
  localparam int unsigned CW    = asef_pkg::COUNT_W;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_ESCAPE  = 2'd1,
    MODE_COLLECT = 2'd2
  } mode_t;

  mode_t                  mode_r, mode_nxt;
  logic [SEQ_W-1:0]       seq_len_r, seq_len_nxt;
  logic [NP-1:0][PW-1:0]  vals_r, vals_nxt;
  logic [CW-1:0]          idx_r, idx_nxt;
  logic                   last_sep_r, last_sep_nxt;
  logic                   any_char_r, any_char_nxt;

  logic                   is_digit;
  logic [PW-1:0]          cur_val;
  logic [PW+3:0]          acc;
  logic [CW-1:0]          count;

  always_comb begin
    is_digit = (byte_in >= asef_pkg::CH_ZERO) && (byte_in <= asef_pkg::CH_NINE);
    cur_val  = (idx_r < CW'(NP)) ? vals_r[idx_r] : '0;
    acc      = ({4'b0, cur_val} << 3) + ({4'b0, cur_val} << 1) + {{PW{1'b0}}, byte_in[3:0]};
    count    = idx_r + CW'(any_char_r && !last_sep_r);
    if (count > CW'(NP)) begin
      count = CW'(NP);
    end

    mode_nxt     = mode_r;
    seq_len_nxt  = seq_len_r;
    vals_nxt     = vals_r;
    idx_nxt      = idx_r;
    last_sep_nxt = last_sep_r;
    any_char_nxt = any_char_r;
    emit         = 1'b0;
    res          = '0;

    unique case (mode_r)
      MODE_ESCAPE: begin
        mode_nxt = MODE_NORMAL;
        if (byte_in == asef_pkg::CH_LBRACKET) begin
          mode_nxt     = MODE_COLLECT;
          seq_len_nxt  = '0;
          vals_nxt     = '0;
          idx_nxt      = '0;
          last_sep_nxt = 1'b0;
          any_char_nxt = 1'b0;
        end
      end
      MODE_COLLECT: begin
        if (byte_in == asef_pkg::CH_M) begin
          emit      = 1'b1;
          res.kind  = asef_pkg::KIND_SGR;
          res.count = count;
          for (int j = 0; j < NP; j++) begin
            res.values[j] = (CW'(j) < count) ? vals_r[j] : '0;
          end
          mode_nxt     = MODE_NORMAL;
          seq_len_nxt  = '0;
          vals_nxt     = '0;
          idx_nxt      = '0;
          last_sep_nxt = 1'b0;
          any_char_nxt = 1'b0;
        end else if ((is_digit || byte_in == asef_pkg::CH_SEMI) &&
                     (seq_len_r < SEQ_W'(MAX_SEQ_CHARS))) begin
          seq_len_nxt  = seq_len_r + SEQ_W'(1);
          any_char_nxt = 1'b1;
          if (byte_in == asef_pkg::CH_SEMI) begin
            if (idx_r < CW'(NP)) begin
              idx_nxt = idx_r + CW'(1);
            end
            last_sep_nxt = 1'b1;
          end else begin
            last_sep_nxt = 1'b0;
            if (idx_r < CW'(NP)) begin
              vals_nxt[idx_r] = (acc[PW+3:PW] != '0) ? {PW{1'b1}} : acc[PW-1:0];
            end
          end
        end else begin
          // abort: stray byte or sequence too long
          mode_nxt     = MODE_NORMAL;
          seq_len_nxt  = '0;
          vals_nxt     = '0;
          idx_nxt      = '0;
          last_sep_nxt = 1'b0;
          any_char_nxt = 1'b0;
        end
      end
      default: begin
        mode_nxt = MODE_NORMAL;
        if (byte_in == asef_pkg::CH_ESC) begin
          mode_nxt = MODE_ESCAPE;
        end else begin
          emit     = 1'b1;
          res.kind = asef_pkg::KIND_CHAR;
          res.chr  = byte_in;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_NORMAL;
      seq_len_r  <= '0;
      vals_r     <= '0;
      idx_r      <= '0;
      last_sep_r <= 1'b0;
      any_char_r <= 1'b0;
    end else if (step) begin
      mode_r     <= mode_nxt;
      seq_len_r  <= seq_len_nxt;
      vals_r     <= vals_nxt;
      idx_r      <= idx_nxt;
      last_sep_r <= last_sep_nxt;
      any_char_r <= any_char_nxt;
    end
  end

endmodule

FILE: rtl/ansi_sgr_escape_filter.sv
// top level: console byte filter that strips csi sequences and decodes sgr commands
//
// one byte enters per request on the in_ channel. ordinary bytes come out as
// character results (tuser 0); esc opens a sequence, esc '[' starts collecting
// digits and semicolons, and the closing 'm' gives one sgr command result
// (tuser 1) with up to five decimal parameters. all other sequence bytes are
// dropped without a result.
// a byte accepted on in_ is registered in the input register, parsed from there
// and its result is registered in the result register that drives out_.
// throughput: one byte per cycle unless a finished result waits on out_tready,
// set by the single parse step between the input and result registers.
// the result register holds a finished result while out_tready is low; the
// input register keeps taking bytes as long as the pending byte makes no
// result or the result register can be freed in the same cycle.
// reset (rst_n low, synchronous) empties both registers and returns the
// parser to passthrough mode with all sequence state cleared.
`timescale 1ns / 1ps

module ansi_sgr_escape_filter #(
  parameter int unsigned MAX_SEQ_CHARS = asef_pkg::MAX_SEQ_CHARS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [asef_pkg::BYTE_W-1:0]        in_tdata,   // in_byte
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_byte, param_count, param_first .. param_fifth, zero pad
  output logic [asef_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tuser   // result_kind
);

  localparam int unsigned RES_DATA_W = $bits(asef_pkg::sgr_result_t) - 1;

  logic [asef_pkg::BYTE_W-1:0]  in_byte_r;
  logic                         in_valid_r, in_valid_nxt;
  logic                         out_valid_r, out_valid_nxt;
  asef_pkg::sgr_result_t        out_res_r;

  logic                         emit;
  asef_pkg::sgr_result_t        res;
  logic                         out_free;
  logic                         step;

  asef_parser #(
    .MAX_SEQ_CHARS (MAX_SEQ_CHARS)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .byte_in (in_byte_r),
    .emit    (emit),
    .res     (res)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign step      = in_valid_r && (!emit || out_free);
  assign in_tready = !in_valid_r || step;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
    if (step && emit) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {{(asef_pkg::OUT_DATA_W - RES_DATA_W){1'b0}},
                       out_res_r.values, out_res_r.count, out_res_r.chr};

endmodule
